FILE: rtl/gray_tone_adjust_and_dither_quantizer_defines.svh
// Assertion macros used by the checker file of the gray tone quantizer.
`ifndef GRAY_TONE_ADJUST_AND_DITHER_QUANTIZER_DEFINES_SVH
`define GRAY_TONE_ADJUST_AND_DITHER_QUANTIZER_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define GTADQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define GTADQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/gtadq_pkg.sv
// Shared types, constants and register codes of the gray tone quantizer.
`timescale 1ns / 1ps
`default_nettype none

package gtadq_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int GRAY_W         = 8;
    localparam int LEVEL_W        = 2;
    localparam int M_FIELDS_W     = LEVEL_W + GRAY_W;
    localparam int M_DATA_W       = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 8;
    localparam int STAGES         = 8;
    localparam int HASH_STAGES    = 3;
    localparam int DIV_STEPS      = 3;

    // Noise hash multipliers
    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
    localparam int          HASH_SHIFT   = 13;

    // Divide by 100 as multiply by 5243 / 2^19, exact for magnitudes below 2^15
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [7:0] GRAY_MAX   = 8'd255;
    localparam logic [7:0] GRAY_MID   = 8'd128;
    localparam logic [7:0] THR_LEVEL1 = 8'd45;
    localparam logic [7:0] THR_LEVEL2 = 8'd70;
    localparam logic [7:0] THR_LEVEL3 = 8'd140;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ADJUST_ENABLE    = 3'd0,
        CFG_CONTRAST_PERCENT = 3'd1,
        CFG_BRIGHT_OFFSET    = 3'd2,
        CFG_GAMMA_ENABLE     = 3'd3,
        CFG_NOISE_ENABLE     = 3'd4,
        CFG_ONE_BIT_MODE     = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic       adjust_enable;
        logic [7:0] contrast_percent;
        logic [5:0] bright_offset;
        logic       gamma_enable;
        logic       noise_enable;
        logic       one_bit_mode;
    } cfg_t;

    localparam logic       RST_ADJUST_ENABLE    = 1'b0;
    localparam logic [7:0] RST_CONTRAST_PERCENT = 8'd115;
    localparam logic [5:0] RST_BRIGHT_OFFSET    = 6'd10;
    localparam logic       RST_GAMMA_ENABLE     = 1'b0;
    localparam logic       RST_NOISE_ENABLE     = 1'b0;
    localparam logic       RST_ONE_BIT_MODE     = 1'b0;

    // One load enable per pipeline stage, stage 0 first
    typedef logic [STAGES-1:0] stage_en_t;

endpackage

`default_nettype wire

FILE: rtl/gray_tone_adjust_and_dither_quantizer.sv
// Top level of the gray tone adjust and dither quantizer.
//
//  channel   dir  tdata bits (low first)               tuser  tlast
//  s_*       in   gray_in[7:0], column, row, zero pad   -      -
//  m_*       out  level[1:0], adjusted_gray[7:0], pad   -      -
//  cfg_*     in   write enable, register index, data    -      -
//
// Eight register stages, one pixel per clock while the output is not stalled.
// Depth is set by the contrast divide, the 3-bit-per-stage gamma divider and
// the 32-bit hash multipliers; the hash runs beside the tone stages.
// Each stage holds while its successor is full and stalled, so bubbles close up.
// rst_n clears the valid bits and resets the configuration registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gray_tone_adjust_and_dither_quantizer #(
    parameter int  COORD_BITS = gtadq_pkg::COORD_BITS_DEF,
    localparam int S_DATA_W   = ((gtadq_pkg::GRAY_W + 2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_DATA_W-1:0]               s_tdata,  // gray_in, column, row
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gtadq_pkg::M_DATA_W-1:0]    m_tdata,  // level, adjusted_gray
    input  logic                              cfg_we,
    input  logic [gtadq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gtadq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LAST = gtadq_pkg::STAGES - 1;

    gtadq_pkg::cfg_t               cfg_reg;
    gtadq_pkg::stage_en_t          valid_reg;
    gtadq_pkg::stage_en_t          valid_next;
    gtadq_pkg::stage_en_t          stage_rdy;
    logic [gtadq_pkg::GRAY_W-1:0]  tone_gray;
    logic [gtadq_pkg::GRAY_W-1:0]  noise;
    logic [gtadq_pkg::LEVEL_W-1:0] out_level;
    logic [gtadq_pkg::GRAY_W-1:0]  out_gray;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adjust_enable    <= gtadq_pkg::RST_ADJUST_ENABLE;
            cfg_reg.contrast_percent <= gtadq_pkg::RST_CONTRAST_PERCENT;
            cfg_reg.bright_offset    <= gtadq_pkg::RST_BRIGHT_OFFSET;
            cfg_reg.gamma_enable     <= gtadq_pkg::RST_GAMMA_ENABLE;
            cfg_reg.noise_enable     <= gtadq_pkg::RST_NOISE_ENABLE;
            cfg_reg.one_bit_mode     <= gtadq_pkg::RST_ONE_BIT_MODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gtadq_pkg::CFG_ADJUST_ENABLE:    cfg_reg.adjust_enable    <= cfg_data[0];
                gtadq_pkg::CFG_CONTRAST_PERCENT: cfg_reg.contrast_percent <= cfg_data[7:0];
                gtadq_pkg::CFG_BRIGHT_OFFSET:    cfg_reg.bright_offset    <= cfg_data[5:0];
                gtadq_pkg::CFG_GAMMA_ENABLE:     cfg_reg.gamma_enable     <= cfg_data[0];
                gtadq_pkg::CFG_NOISE_ENABLE:     cfg_reg.noise_enable     <= cfg_data[0];
                gtadq_pkg::CFG_ONE_BIT_MODE:     cfg_reg.one_bit_mode     <= cfg_data[0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on this cycle
    always_comb
    begin
        stage_rdy[LAST] = !valid_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next[0] = stage_rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k <= LAST; k++)
        begin
            valid_next[k] = stage_rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[LAST];

    gtadq_tone u_tone (
        .clk      (clk),
        .en       (stage_rdy),
        .cfg      (cfg_reg),
        .gray_in  (s_tdata[gtadq_pkg::GRAY_W-1:0]),
        .gray_out (tone_gray)
    );

    gtadq_hash #(
        .COORD_BITS (COORD_BITS)
    ) u_hash (
        .clk    (clk),
        .en     (stage_rdy),
        .column (s_tdata[gtadq_pkg::GRAY_W +: COORD_BITS]),
        .row    (s_tdata[gtadq_pkg::GRAY_W + COORD_BITS +: COORD_BITS]),
        .noise  (noise)
    );

    gtadq_quant u_quant (
        .clk           (clk),
        .en            (stage_rdy[LAST]),
        .cfg           (cfg_reg),
        .gray          (tone_gray),
        .noise         (noise),
        .level         (out_level),
        .adjusted_gray (out_gray)
    );

    assign m_tdata = {{(gtadq_pkg::M_DATA_W - gtadq_pkg::M_FIELDS_W){1'b0}}, out_gray, out_level};

endmodule

`default_nettype wire

FILE: rtl/gtadq_hash.sv
// Coordinate noise hash pipeline, delivering the 8-bit threshold at stage 6.
`timescale 1ns / 1ps
`default_nettype none

module gtadq_hash #(
    parameter int COORD_BITS = gtadq_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  gtadq_pkg::stage_en_t         en,
    input  logic [COORD_BITS-1:0]        column,
    input  logic [COORD_BITS-1:0]        row,
    output logic [gtadq_pkg::GRAY_W-1:0] noise
);

    localparam int LAST = gtadq_pkg::STAGES - 2;

    logic [31:0] px_next;
    logic [31:0] py_next;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] hash_sum;
    logic [31:0] mix_next;
    logic [31:0] mix_reg;
    logic [31:0] scramble;
    logic [gtadq_pkg::GRAY_W-1:0] noise_pipe_reg [gtadq_pkg::HASH_STAGES-1:LAST];

    always_comb
    begin
        px_next  = 32'(column) * gtadq_pkg::HASH_MUL_X;
        py_next  = 32'(row) * gtadq_pkg::HASH_MUL_Y;
        hash_sum = px_reg + py_reg;
        mix_next = hash_sum ^ (hash_sum >> gtadq_pkg::HASH_SHIFT);
        scramble = mix_reg * gtadq_pkg::HASH_MUL_MIX;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (en[1])
        begin
            mix_reg <= mix_next;
        end
        if (en[2])
        begin
            noise_pipe_reg[gtadq_pkg::HASH_STAGES-1] <= scramble[31:24];
        end
        // carry the threshold alongside the tone pipeline
        for (int k = gtadq_pkg::HASH_STAGES; k <= LAST; k++)
        begin
            if (en[k])
            begin
                noise_pipe_reg[k] <= noise_pipe_reg[k-1];
            end
        end
    end

    assign noise = noise_pipe_reg[LAST];

endmodule

`default_nettype wire

FILE: rtl/gtadq_tone.sv
// Tone pipeline: contrast, brightness and square-root gamma over stages 0 to 6.
`timescale 1ns / 1ps
`default_nettype none

module gtadq_tone (
    input  logic                         clk,
    input  gtadq_pkg::stage_en_t         en,
    input  gtadq_pkg::cfg_t              cfg,
    input  logic [gtadq_pkg::GRAY_W-1:0] gray_in,
    output logic [gtadq_pkg::GRAY_W-1:0] gray_out
);

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [8:0] div_step(
        input logic [7:0] rem,
        input logic       dividend_bit,
        input logic [7:0] divisor
    );
        logic [8:0] trial;
        logic [8:0] diff;
        logic [8:0] result;
        trial = {rem, dividend_bit};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            result = {1'b1, diff[7:0]};
        end
        else
        begin
            result = {1'b0, trial[7:0]};
        end
        return result;
    endfunction

    // stage 0: contrast product
    logic signed [8:0]  gray_dev;
    logic signed [17:0] prod_next;
    logic signed [17:0] s0_prod_reg;
    logic [7:0]         s0_gray_reg;

    // stage 1: divide by 100
    logic signed [17:0] prod_abs;
    logic [14:0]        prod_mag;
    logic [27:0]        quot_wide;
    logic               s1_neg_reg;
    logic [8:0]         s1_quot_reg;
    logic [7:0]         s1_gray_reg;

    // stage 2: recenter, clamp, brightness
    logic signed [10:0] contrast_val;
    logic [7:0]         contrast_clamp;
    logic [8:0]         bright_sum;
    logic [7:0]         bright_clamp;
    logic [7:0]         s2_gray_next;
    logic [7:0]         s2_gray_reg;

    // stages 3 to 5: p = g * 255 divided by r1 = (g + 255) / 2
    logic [15:0]        prod255;
    logic [8:0]         root_sum;
    logic [7:0]         divisor_next;
    logic [8:0]         step3;
    logic [8:0]         step4;
    logic [8:0]         step5;
    logic [7:0]         rem3;
    logic [7:0]         rem4;
    logic [7:0]         rem5;
    logic [2:0]         quot3_next;
    logic [2:0]         quot4_bits;
    logic [2:0]         quot5_bits;
    logic [7:0]         s3_gray_reg;
    logic [7:0]         s3_div_reg;
    logic [7:0]         s3_rem_reg;
    logic [2:0]         s3_quot_reg;
    logic [5:0]         s3_low_reg;
    logic [7:0]         s4_gray_reg;
    logic [7:0]         s4_div_reg;
    logic [7:0]         s4_rem_reg;
    logic [5:0]         s4_quot_reg;
    logic [2:0]         s4_low_reg;
    logic [7:0]         s5_gray_reg;
    logic [7:0]         s5_div_reg;
    logic [8:0]         s5_quot_reg;

    // stage 6: second Newton average and select
    logic [9:0]         root_avg;
    logic [8:0]         root_val;
    logic [7:0]         root_cap;
    logic [7:0]         s6_gray_next;
    logic [7:0]         s6_gray_reg;

    always_comb
    begin
        gray_dev  = $signed({1'b0, gray_in}) - 9'sd128;
        prod_next = 18'(gray_dev) * 18'($signed({1'b0, cfg.contrast_percent}));
    end

    always_comb
    begin
        prod_abs  = s0_prod_reg[17] ? -s0_prod_reg : s0_prod_reg;
        prod_mag  = prod_abs[14:0];
        quot_wide = 28'(prod_mag) * 28'(gtadq_pkg::RECIP_100);
    end

    always_comb
    begin
        contrast_val = s1_neg_reg ? (11'sd128 - $signed({2'b00, s1_quot_reg}))
                                  : (11'sd128 + $signed({2'b00, s1_quot_reg}));
        priority if (contrast_val < 11'sd0)
        begin
            contrast_clamp = '0;
        end
        else if (contrast_val > 11'sd255)
        begin
            contrast_clamp = gtadq_pkg::GRAY_MAX;
        end
        else
        begin
            contrast_clamp = contrast_val[7:0];
        end
        bright_sum   = {1'b0, contrast_clamp} + {3'b000, cfg.bright_offset};
        bright_clamp = bright_sum[8] ? gtadq_pkg::GRAY_MAX : bright_sum[7:0];
        s2_gray_next = cfg.adjust_enable ? bright_clamp : s1_gray_reg;
    end

    // first Newton step from r = g is exact: (g + g*255/g) / 2 = (g + 255) / 2
    always_comb
    begin
        prod255      = {s2_gray_reg, 8'd0} - {8'd0, s2_gray_reg};
        root_sum     = {1'b0, s2_gray_reg} + {1'b0, gtadq_pkg::GRAY_MAX};
        divisor_next = root_sum[8:1];
        step3        = '0;
        rem3         = {1'b0, prod255[15:9]};
        quot3_next   = '0;
        for (int i = 0; i < gtadq_pkg::DIV_STEPS; i++)
        begin
            step3             = div_step(rem3, prod255[8-i], divisor_next);
            quot3_next[2-i]   = step3[8];
            rem3              = step3[7:0];
        end
    end

    always_comb
    begin
        step4      = '0;
        rem4       = s3_rem_reg;
        quot4_bits = '0;
        for (int i = 0; i < gtadq_pkg::DIV_STEPS; i++)
        begin
            step4           = div_step(rem4, s3_low_reg[5-i], s3_div_reg);
            quot4_bits[2-i] = step4[8];
            rem4            = step4[7:0];
        end
    end

    always_comb
    begin
        step5      = '0;
        rem5       = s4_rem_reg;
        quot5_bits = '0;
        for (int i = 0; i < gtadq_pkg::DIV_STEPS; i++)
        begin
            step5           = div_step(rem5, s4_low_reg[2-i], s4_div_reg);
            quot5_bits[2-i] = step5[8];
            rem5            = step5[7:0];
        end
    end

    always_comb
    begin
        root_avg = {2'b00, s5_div_reg} + {1'b0, s5_quot_reg};
        root_val = root_avg[9:1];
        root_cap = root_val[8] ? gtadq_pkg::GRAY_MAX : root_val[7:0];
        // black stays black under gamma
        if (cfg.adjust_enable && cfg.gamma_enable && (s5_gray_reg != '0))
        begin
            s6_gray_next = root_cap;
        end
        else if (cfg.adjust_enable && cfg.gamma_enable)
        begin
            s6_gray_next = '0;
        end
        else
        begin
            s6_gray_next = s5_gray_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_prod_reg <= prod_next;
            s0_gray_reg <= gray_in;
        end
        if (en[1])
        begin
            s1_neg_reg  <= s0_prod_reg[17];
            s1_quot_reg <= quot_wide[gtadq_pkg::RECIP_SHIFT +: 9];
            s1_gray_reg <= s0_gray_reg;
        end
        if (en[2])
        begin
            s2_gray_reg <= s2_gray_next;
        end
        if (en[3])
        begin
            s3_gray_reg <= s2_gray_reg;
            s3_div_reg  <= divisor_next;
            s3_rem_reg  <= rem3;
            s3_quot_reg <= quot3_next;
            s3_low_reg  <= prod255[5:0];
        end
        if (en[4])
        begin
            s4_gray_reg <= s3_gray_reg;
            s4_div_reg  <= s3_div_reg;
            s4_rem_reg  <= rem4;
            s4_quot_reg <= {s3_quot_reg, quot4_bits};
            s4_low_reg  <= s3_low_reg[2:0];
        end
        if (en[5])
        begin
            s5_gray_reg <= s4_gray_reg;
            s5_div_reg  <= s4_div_reg;
            s5_quot_reg <= {s4_quot_reg, quot5_bits};
        end
        if (en[6])
        begin
            s6_gray_reg <= s6_gray_next;
        end
    end

    assign gray_out = s6_gray_reg;

endmodule

`default_nettype wire

FILE: rtl/gtadq_quant.sv
// Output stage: quantize the adjusted gray to a level and hold the result.
`timescale 1ns / 1ps
`default_nettype none

module gtadq_quant (
    input  logic                          clk,
    input  logic                          en,
    input  gtadq_pkg::cfg_t               cfg,
    input  logic [gtadq_pkg::GRAY_W-1:0]  gray,
    input  logic [gtadq_pkg::GRAY_W-1:0]  noise,
    output logic [gtadq_pkg::LEVEL_W-1:0] level,
    output logic [gtadq_pkg::GRAY_W-1:0]  adjusted_gray
);

    logic signed [8:0]             noise_dev;
    logic signed [8:0]             noise_adj;
    logic signed [8:0]             noise_half;
    logic signed [8:0]             one_bit_thr;
    logic [9:0]                    gray_x3;
    logic [10:0]                   dither_sum;
    logic [gtadq_pkg::LEVEL_W-1:0] level_next;
    logic [gtadq_pkg::LEVEL_W-1:0] level_reg;
    logic [gtadq_pkg::GRAY_W-1:0]  gray_reg;

    always_comb
    begin
        // threshold 128 + (t - 128) / 2, halved toward zero
        noise_dev   = $signed({1'b0, noise}) - 9'sd128;
        noise_adj   = noise_dev + $signed({8'd0, noise_dev[8]});
        noise_half  = noise_adj >>> 1;
        one_bit_thr = 9'sd128 + noise_half;
        gray_x3     = {1'b0, gray, 1'b0} + {2'b00, gray};
        dither_sum  = {1'b0, gray_x3} + {3'b000, noise};
        priority if (cfg.one_bit_mode)
        begin
            level_next = ($signed({1'b0, gray}) >= one_bit_thr) ? 2'd1 : 2'd0;
        end
        else if (cfg.noise_enable)
        begin
            priority if (gray_x3 < 10'd255)
            begin
                level_next = (dither_sum >= 11'd255) ? 2'd1 : 2'd0;
            end
            else if (gray_x3 < 10'd510)
            begin
                level_next = (dither_sum >= 11'd510) ? 2'd2 : 2'd1;
            end
            else
            begin
                level_next = (dither_sum >= 11'd765) ? 2'd3 : 2'd2;
            end
        end
        else
        begin
            priority if (gray < gtadq_pkg::THR_LEVEL1)
            begin
                level_next = 2'd0;
            end
            else if (gray < gtadq_pkg::THR_LEVEL2)
            begin
                level_next = 2'd1;
            end
            else if (gray < gtadq_pkg::THR_LEVEL3)
            begin
                level_next = 2'd2;
            end
            else
            begin
                level_next = 2'd3;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= level_next;
            gray_reg  <= gray;
        end
    end

    assign level         = level_reg;
    assign adjusted_gray = gray_reg;

endmodule

`default_nettype wire

FILE: rtl/gtadq_checker.sv
// Port-level checker of the gray tone quantizer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "gray_tone_adjust_and_dither_quantizer_defines.svh"

module gtadq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [gtadq_pkg::M_DATA_W-1:0] m_tdata
);

    // nothing leaves the block in the cycle after reset is seen
    `GTADQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "m_tvalid high after reset")

    // a stalled result transaction keeps its payload
    `GTADQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

    // an open output never backs up the input
    `GTADQ_ASSERT(a_flow_through, m_tready |-> s_tready, "input stalled with output ready")

    // the input stalls only when the pipeline is full behind a stalled output
    `GTADQ_ASSERT(a_stall_cause, !s_tready |-> m_tvalid && !m_tready, "input stalled without output stall")

    // padding above the result fields stays zero
    `GTADQ_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[gtadq_pkg::M_DATA_W-1:gtadq_pkg::M_FIELDS_W] == '0, "nonzero pad bits")

endmodule

bind gray_tone_adjust_and_dither_quantizer gtadq_checker u_gtadq_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the gray tone adjust and dither quantizer.
`timescale 1ns / 1ps

module tb;
    import gtadq_pkg::*;

    localparam int COORD_W        = 16;
    localparam int S_DATA_W       = ((GRAY_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int PIPE_LATENCY   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_PIXELS   = 80;

    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_HI = 3'd7;

    localparam int MID_GRAY    = 128;
    localparam int FULL_GRAY   = 255;
    localparam int PERCENT     = 100;
    localparam int LEVEL1_FROM = 45;
    localparam int LEVEL2_FROM = 70;
    localparam int LEVEL3_FROM = 140;
    localparam logic [31:0] MIX_X     = 32'd374761393;
    localparam logic [31:0] MIX_Y     = 32'd668265263;
    localparam logic [31:0] MIX_FINAL = 32'd1274126177;
    localparam int          MIX_SHIFT = 13;

    typedef struct packed {
        logic       adjust_enable;
        logic [7:0] contrast_percent;
        logic [5:0] bright_offset;
        logic       gamma_enable;
        logic       noise_enable;
        logic       one_bit_mode;
    } tone_settings_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [GRAY_W-1:0]  gray;
    } pixel_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    tone_settings_t tone = '{
        adjust_enable:    RST_ADJUST_ENABLE,
        contrast_percent: RST_CONTRAST_PERCENT,
        bright_offset:    RST_BRIGHT_OFFSET,
        gamma_enable:     RST_GAMMA_ENABLE,
        noise_enable:     RST_NOISE_ENABLE,
        one_bit_mode:     RST_ONE_BIT_MODE
    };
    pixel_result_t expected_pixels[$];
    int            fail_count = 0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;

    gray_tone_adjust_and_dither_quantizer #(
        .COORD_BITS(COORD_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_gray(input int v);
        if (v < 0)
            return 0;
        if (v > FULL_GRAY)
            return FULL_GRAY;
        return v;
    endfunction

    function automatic int noise_threshold(input logic [COORD_W-1:0] cx,
                                           input logic [COORD_W-1:0] cy);
        logic [31:0] h;
        h = 32'(cx) * MIX_X + 32'(cy) * MIX_Y;
        h = (h ^ (h >> MIX_SHIFT)) * MIX_FINAL;
        return int'(h[31:24]);
    endfunction

    function automatic pixel_result_t quantize_pixel(input logic [GRAY_W-1:0] gray_in,
                                                     input logic [COORD_W-1:0] cx,
                                                     input logic [COORD_W-1:0] cy);
        int g;
        int p;
        int r;
        int t;
        int s;
        pixel_result_t res;
        g = int'(gray_in);
        if (tone.adjust_enable)
        begin
            g = clamp_gray(((g - MID_GRAY) * int'(tone.contrast_percent)) / PERCENT + MID_GRAY);
            g = clamp_gray(g + int'(tone.bright_offset));
            if (tone.gamma_enable && g > 0)
            begin
                // two Newton steps toward sqrt(g * 255)
                p = g * FULL_GRAY;
                r = g;
                r = (r + p / r) >> 1;
                r = (r + p / r) >> 1;
                g = (r > FULL_GRAY) ? FULL_GRAY : r;
            end
        end
        if (tone.one_bit_mode)
        begin
            t = noise_threshold(cx, cy);
            res.level = (g >= MID_GRAY + (t - MID_GRAY) / 2) ? 2'd1 : 2'd0;
        end
        else if (tone.noise_enable)
        begin
            t = noise_threshold(cx, cy);
            s = 3 * g;
            if (s < FULL_GRAY)
                res.level = (s + t >= FULL_GRAY) ? 2'd1 : 2'd0;
            else if (s < 2 * FULL_GRAY)
                res.level = (s - FULL_GRAY + t >= FULL_GRAY) ? 2'd2 : 2'd1;
            else
                res.level = (s - 2 * FULL_GRAY + t >= FULL_GRAY) ? 2'd3 : 2'd2;
        end
        else if (g < LEVEL1_FROM)
            res.level = 2'd0;
        else if (g < LEVEL2_FROM)
            res.level = 2'd1;
        else if (g < LEVEL3_FROM)
            res.level = 2'd2;
        else
            res.level = 2'd3;
        res.gray = g[GRAY_W-1:0];
        return res;
    endfunction

    // Mostly short idles, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_ADJUST_ENABLE:    tone.adjust_enable    = value[0];
            CFG_CONTRAST_PERCENT: tone.contrast_percent = value;
            CFG_BRIGHT_OFFSET:    tone.bright_offset    = value[5:0];
            CFG_GAMMA_ENABLE:     tone.gamma_enable     = value[0];
            CFG_NOISE_ENABLE:     tone.noise_enable     = value[0];
            CFG_ONE_BIT_MODE:     tone.one_bit_mode     = value[0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [GRAY_W-1:0] gray_in,
                              input logic [COORD_W-1:0] cx,
                              input logic [COORD_W-1:0] cy);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cy, cx, gray_in};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        expected_pixels.push_back(quantize_pixel(gray_in, cx, cy));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_fixed_thresholds();
        logic [7:0] grays[8] = '{8'd0, 8'd44, 8'd45, 8'd69, 8'd70, 8'd139, 8'd140, 8'd255};
        foreach (grays[i])
            send_pixel(grays[i], (i % 2) ? 16'hFFFF : 16'h0000, (i % 2) ? 16'hFFFF : 16'h0000);
        wait_drained();
    endtask

    task automatic test_tone_extremes();
        write_reg(CFG_ADJUST_ENABLE, 8'd1);
        write_reg(CFG_CONTRAST_PERCENT, 8'd255);
        write_reg(CFG_BRIGHT_OFFSET, 8'd50);
        send_pixel(8'd0, 16'd1, 16'd2);
        send_pixel(8'd255, 16'd3, 16'd4);
        send_pixel(8'd128, 16'd5, 16'd6);
        wait_drained();
        write_reg(CFG_CONTRAST_PERCENT, 8'd0);
        send_pixel(8'd255, 16'd7, 16'd8);
        wait_drained();
        // oversized value: only the low six bits land, a boost past 50
        write_reg(CFG_BRIGHT_OFFSET, 8'hFF);
        write_reg(CFG_CONTRAST_PERCENT, 8'd100);
        send_pixel(8'd250, 16'd9, 16'd10);
        wait_drained();
        write_reg(CFG_BRIGHT_OFFSET, 8'd0);
        write_reg(CFG_GAMMA_ENABLE, 8'd1);
        send_pixel(8'd0, 16'd11, 16'd12);
        send_pixel(8'd255, 16'd13, 16'd14);
        send_pixel(8'd64, 16'd15, 16'd16);
        wait_drained();
    endtask

    task automatic test_noise_modes();
        logic [7:0] grays[5] = '{8'd0, 8'd84, 8'd85, 8'd170, 8'd255};
        // writes to unused indexes must change nothing
        write_reg(IDX_UNUSED_LO, 8'hFF);
        write_reg(IDX_UNUSED_HI, 8'hFF);
        write_reg(CFG_ADJUST_ENABLE, 8'hFE);
        write_reg(CFG_NOISE_ENABLE, 8'd1);
        foreach (grays[i])
            send_pixel(grays[i], 16'($urandom), 16'($urandom));
        wait_drained();
        write_reg(CFG_ONE_BIT_MODE, 8'd1);
        send_pixel(8'd0, 16'h0000, 16'h0000);
        send_pixel(8'd128, 16'hFFFF, 16'h0000);
        send_pixel(8'd255, 16'h0000, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random_settings();
        logic [7:0] gray;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(CFG_ADJUST_ENABLE, 8'd1);
                write_reg(CFG_CONTRAST_PERCENT, 8'd255);
                write_reg(CFG_BRIGHT_OFFSET, 8'd63);
                write_reg(CFG_GAMMA_ENABLE, 8'd1);
                write_reg(CFG_NOISE_ENABLE, 8'd1);
                write_reg(CFG_ONE_BIT_MODE, 8'd0);
            end
            else if (phase == 1)
            begin
                write_reg(CFG_CONTRAST_PERCENT, 8'd0);
                write_reg(CFG_BRIGHT_OFFSET, 8'd0);
                write_reg(CFG_GAMMA_ENABLE, 8'd0);
                write_reg(CFG_NOISE_ENABLE, 8'd0);
                write_reg(CFG_ONE_BIT_MODE, 8'd1);
            end
            else
            begin
                write_reg(CFG_ADJUST_ENABLE, 8'($urandom));
                write_reg(CFG_CONTRAST_PERCENT, 8'($urandom));
                write_reg(CFG_BRIGHT_OFFSET, 8'($urandom));
                write_reg(CFG_GAMMA_ENABLE, 8'($urandom));
                write_reg(CFG_NOISE_ENABLE, 8'($urandom));
                write_reg(CFG_ONE_BIT_MODE, ($urandom_range(0, 2) == 0) ? 8'd1 : 8'd0);
                if ($urandom_range(0, 3) == 0)
                    write_reg($urandom_range(0, 1) ? IDX_UNUSED_LO : IDX_UNUSED_HI, 8'($urandom));
            end
            quiet = (phase % 4 == 3);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    gray = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                else
                    gray = 8'($urandom);
                send_pixel(gray, 16'($urandom), 16'($urandom));
            end
            wait_drained();
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        pixel_result_t got;
        pixel_result_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got.level = m_tdata[LEVEL_W-1:0];
            got.gray  = m_tdata[LEVEL_W +: GRAY_W];
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected transaction, level %0d gray %0d",
                         $time, got.level, got.gray);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.level !== want.level)
                begin
                    $display("%0t: level expected %0d, actual %0d", $time, want.level, got.level);
                    fail_count++;
                end
                if (got.gray !== want.gray)
                begin
                    $display("%0t: adjusted_gray expected %0d, actual %0d",
                             $time, want.gray, got.gray);
                    fail_count++;
                end
            end
        end
        // random back-pressure on the result side
        if (!rst_n || (!quiet && stall_left > 0))
        begin
            m_tready <= 1'b0;
            if (stall_left > 0)
                stall_left--;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            m_tready   <= 1'b0;
            stall_left = idle_length() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fixed_thresholds();
        test_tone_extremes();
        test_noise_modes();
        test_random_settings();
        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gtadq_pkg.sv
rtl/gtadq_hash.sv
rtl/gtadq_tone.sv
rtl/gtadq_quant.sv
rtl/gray_tone_adjust_and_dither_quantizer.sv
rtl/gtadq_checker.sv
tb/tb.sv
